[design/hpfp_pkg.sv]
// Shared types and codes for the HPACK header field parser.
package hpfp_pkg;

	// Parser phases
	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_REP   = 3'd1;
	localparam logic [2:0] PH_NLEN0 = 3'd2;
	localparam logic [2:0] PH_NLEN  = 3'd3;
	localparam logic [2:0] PH_NAME  = 3'd4;
	localparam logic [2:0] PH_VLEN0 = 3'd5;
	localparam logic [2:0] PH_VLEN  = 3'd6;
	localparam logic [2:0] PH_VALUE = 3'd7;

	// Result item kinds
	localparam logic [2:0] KIND_INT_MORE   = 3'd0;
	localparam logic [2:0] KIND_INT_DONE   = 3'd1;
	localparam logic [2:0] KIND_NAME_LEN   = 3'd2;
	localparam logic [2:0] KIND_NAME_BYTE  = 3'd3;
	localparam logic [2:0] KIND_VALUE_LEN  = 3'd4;
	localparam logic [2:0] KIND_VALUE_BYTE = 3'd5;

	// Representation types
	localparam logic [2:0] REP_INDEXED = 3'd0;
	localparam logic [2:0] REP_INCR    = 3'd1;
	localparam logic [2:0] REP_WITHOUT = 3'd2;
	localparam logic [2:0] REP_NEVER   = 3'd3;
	localparam logic [2:0] REP_SIZE    = 3'd4;

	// Error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_LIMIT     = 3'd1;
	localparam logic [2:0] ERR_ZERO_IDX  = 3'd2;
	localparam logic [2:0] ERR_LATE_SIZE = 3'd3;
	localparam logic [2:0] ERR_STR_LONG  = 3'd4;
	localparam logic [2:0] ERR_EOS_RUN   = 3'd5;
	localparam logic [2:0] ERR_TRUNC     = 3'd6;

	// Configuration register indexes
	localparam logic [1:0] CFG_MAX_INTEGER   = 2'd0;
	localparam logic [1:0] CFG_MAX_NAME_LEN  = 2'd1;
	localparam logic [1:0] CFG_MAX_VALUE_LEN = 2'd2;

	localparam logic [31:0] MAX_INTEGER_RST   = 32'd65535;
	localparam logic [15:0] MAX_NAME_LEN_RST  = 16'd256;
	localparam logic [15:0] MAX_VALUE_LEN_RST = 16'd256;

	// Integer decode: 7-bit groups, largest live shift is 28, so a sum fits 36 bits
	localparam int          SUM_W      = 36;
	localparam logic [5:0]  SHIFT_STEP = 6'd7;
	localparam logic [5:0]  SHIFT_SAT  = 6'd63;
	localparam logic [5:0]  SHIFT_LIVE = 6'd32;
	localparam logic [5:0]  EOS_RUN    = 6'd30;

	typedef struct packed {
		logic [2:0] phase;
		logic [2:0] rep_kind;
		logic [5:0] shift;
		logic       huff;
		logic       field_seen;
		logic [4:0] ones_run;
		logic [2:0] err;
	} ctl_t;

	typedef struct packed {
		logic [2:0]  item_kind;
		logic [2:0]  rep_type;
		logic [31:0] int_value;
		logic [7:0]  string_byte;
		logic        huff_flag;
		logic        string_last;
		logic        field_done;
		logic [2:0]  error_code;
	} res_t;

endpackage

[design/hpfp_step.sv]
// Next-state and result logic for one header block octet.
module hpfp_step #(
	parameter int ACC_W = 32
) (
	input  hpfp_pkg::ctl_t    ctl,
	input  logic [ACC_W-1:0]  acc,
	input  logic [ACC_W-1:0]  rem,
	input  logic [7:0]        in_byte,
	input  logic              blk_end,
	input  logic [31:0]       max_integer,
	input  logic [15:0]       max_name_len,
	input  logic [15:0]       max_value_len,
	output hpfp_pkg::ctl_t    ctl_n,
	output logic [ACC_W-1:0]  acc_n,
	output logic [ACC_W-1:0]  rem_n,
	output hpfp_pkg::res_t    res
);
	import hpfp_pkg::*;

	localparam logic [31:0] ACC_MAX = 32'((64'd1 << ACC_W) - 64'd1);

	function automatic logic [3:0] lead_ones(input logic [7:0] b);
		logic [3:0] n;
		logic       run;
		n   = 4'd0;
		run = 1'b1;
		for (int i = 7; i >= 0; i--) begin
			if (run && b[i]) n = n + 4'd1;
			else run = 1'b0;
		end
		return n;
	endfunction

	function automatic logic [3:0] trail_ones(input logic [7:0] b);
		logic [3:0] n;
		logic       run;
		n   = 4'd0;
		run = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (run && b[i]) n = n + 4'd1;
			else run = 1'b0;
		end
		return n;
	endfunction

	logic [31:0]      lim;
	logic [SUM_W-1:0] cur;
	logic [SUM_W-1:0] sum;
	logic [6:0]       mask;
	logic [6:0]       pval;
	logic [2:0]       err;
	logic             fin_rep;
	logic             fin_len;
	logic             is_name;
	logic [15:0]      cap;
	logic [5:0]       run_sum;
	logic             all_ones;

	assign lim = (max_integer > ACC_MAX) ? ACC_MAX : max_integer;

	always_comb begin
		ctl_n    = ctl;
		rem_n    = rem;
		res      = '0;
		err      = ctl.err;
		cur      = SUM_W'(acc);
		sum      = '0;
		mask     = 7'h7f;
		pval     = '0;
		fin_rep  = 1'b0;
		fin_len  = 1'b0;
		is_name  = 1'b0;
		cap      = '0;
		all_ones = (in_byte == 8'hff);
		run_sum  = 6'({1'b0, ctl.ones_run}) + (all_ones ? 6'd8 : 6'(lead_ones(in_byte)));

		if (ctl.err == ERR_NONE) begin
			unique case (ctl.phase) inside
				PH_START: begin
					if (in_byte[7]) begin
						ctl_n.rep_kind = REP_INDEXED;
						mask = 7'h7f;
					end else if (in_byte[6]) begin
						ctl_n.rep_kind = REP_INCR;
						mask = 7'h3f;
					end else if (in_byte[5]) begin
						ctl_n.rep_kind = REP_SIZE;
						mask = 7'h1f;
					end else if (in_byte[4]) begin
						ctl_n.rep_kind = REP_NEVER;
						mask = 7'h0f;
					end else begin
						ctl_n.rep_kind = REP_WITHOUT;
						mask = 7'h0f;
					end
					pval        = in_byte[6:0] & mask;
					cur         = SUM_W'(pval);
					ctl_n.shift = '0;
					if (pval != mask) fin_rep = 1'b1;
					else ctl_n.phase = PH_REP;
					if (ctl_n.rep_kind != REP_SIZE) ctl_n.field_seen = 1'b1;
				end
				PH_REP, PH_NLEN, PH_VLEN: begin
					// continuation group, least significant first
					if (in_byte[6:0] != 7'd0) begin
						if (ctl.shift >= SHIFT_LIVE) begin
							err = ERR_LIMIT;
						end else begin
							sum = cur + (SUM_W'(in_byte[6:0]) << ctl.shift[4:0]);
							cur = sum;
							if (sum > SUM_W'(lim)) err = ERR_LIMIT;
						end
					end
					ctl_n.shift = (ctl.shift > SHIFT_SAT - SHIFT_STEP) ? SHIFT_SAT
						: ctl.shift + SHIFT_STEP;
					if (ctl.phase == PH_REP) begin
						if (err == ERR_NONE && !in_byte[7]) fin_rep = 1'b1;
					end else begin
						is_name = (ctl.phase == PH_NLEN);
						if (err == ERR_NONE && !in_byte[7]) fin_len = 1'b1;
						else res.huff_flag = ctl.huff;
					end
				end
				PH_NLEN0, PH_VLEN0: begin
					ctl_n.huff  = in_byte[7];
					cur         = SUM_W'(in_byte[6:0]);
					ctl_n.shift = '0;
					is_name     = (ctl.phase == PH_NLEN0);
					if (in_byte[6:0] != 7'h7f) begin
						fin_len = 1'b1;
					end else begin
						res.huff_flag = in_byte[7];
						ctl_n.phase   = is_name ? PH_NLEN : PH_VLEN;
					end
				end
				PH_NAME, PH_VALUE: begin
					is_name          = (ctl.phase == PH_NAME);
					res.item_kind    = is_name ? KIND_NAME_BYTE : KIND_VALUE_BYTE;
					res.string_byte  = in_byte;
					res.huff_flag    = ctl.huff;
					res.string_last  = (rem == ACC_W'(1));
					// run of one bits through this octet
					if (run_sum >= EOS_RUN) err = ERR_EOS_RUN;
					if (all_ones) begin
						ctl_n.ones_run = (run_sum >= EOS_RUN) ? EOS_RUN[4:0] : run_sum[4:0];
					end else begin
						ctl_n.ones_run = 5'(trail_ones(in_byte));
					end
					rem_n = rem - ACC_W'(1);
					if (res.string_last) begin
						if (is_name) begin
							ctl_n.phase = PH_VLEN0;
						end else begin
							res.field_done = 1'b1;
							ctl_n.phase    = PH_START;
						end
					end
				end
			endcase

			if (fin_rep) begin
				res.item_kind = KIND_INT_DONE;
				res.int_value = cur[31:0];
				if (cur > SUM_W'(lim)) begin
					err = ERR_LIMIT;
				end else if (ctl_n.rep_kind == REP_INDEXED && cur == '0) begin
					err = ERR_ZERO_IDX;
				end else if (ctl_n.rep_kind == REP_SIZE && ctl.field_seen) begin
					err = ERR_LATE_SIZE;
				end else if (ctl_n.rep_kind == REP_INDEXED || ctl_n.rep_kind == REP_SIZE) begin
					res.field_done = 1'b1;
					ctl_n.phase    = PH_START;
				end else begin
					ctl_n.phase = (cur == '0) ? PH_NLEN0 : PH_VLEN0;
				end
			end

			if (fin_len) begin
				cap           = is_name ? max_name_len : max_value_len;
				res.item_kind = is_name ? KIND_NAME_LEN : KIND_VALUE_LEN;
				res.int_value = cur[31:0];
				res.huff_flag = ctl_n.huff;
				if (cur > SUM_W'(lim)) begin
					err = ERR_LIMIT;
				end else if (!ctl_n.huff && cur > SUM_W'(cap)) begin
					err = ERR_STR_LONG;
				end else if (cur == '0) begin
					if (is_name) begin
						ctl_n.phase = PH_VLEN0;
					end else begin
						res.field_done = 1'b1;
						ctl_n.phase    = PH_START;
					end
				end else begin
					rem_n          = cur[ACC_W-1:0];
					ctl_n.ones_run = '0;
					ctl_n.phase    = is_name ? PH_NAME : PH_VALUE;
				end
			end
		end

		if (blk_end && err == ERR_NONE && ctl_n.phase != PH_START) err = ERR_TRUNC;

		if (err != ERR_NONE) res = '0;
		res.rep_type   = ctl_n.rep_kind;
		res.error_code = err;

		acc_n     = cur[ACC_W-1:0];
		ctl_n.err = err;

		if (blk_end) begin
			ctl_n.phase      = PH_START;
			ctl_n.shift      = '0;
			ctl_n.huff       = 1'b0;
			ctl_n.field_seen = 1'b0;
			ctl_n.ones_run   = '0;
			ctl_n.err        = ERR_NONE;
			acc_n            = '0;
			rem_n            = '0;
		end
	end

endmodule

[design/hpack_header_field_parser.sv]
// HPACK header field parser: one octet of a header block in, one result item out per transfer.
//
// The parser takes a header block one octet per cycle when results are not stalled, and
// returns exactly one result per octet. The leading bits of a representation pick its type
// (indexed, incremental, size update, never indexed, without indexing); prefix integers are
// completed by 7-bit continuation groups; name and value string octets pass through raw with
// their Huffman flag. Errors (integer over max_integer, index zero, size update after a
// field, raw string over its length limit, 30 one bits in a row inside a string, truncation
// at block_end) are sticky: later octets of the block give results with only rep_type and
// error_code set. All per-block state clears after the octet marked block_end. Throughput is
// one octet per cycle, sustained while out_ready stays high; each octet passes through the
// input register and then the per-octet state update into the result register. The rate is
// set by the octet-to-octet dependency through the phase and integer accumulator registers,
// which are updated once per octet. Configuration writes are taken at any time with
// cfg_ready held high and must only be issued while the parser is idle. INT_WIDTH (16..64)
// caps the decoded integer range at 2^min(INT_WIDTH,32)-1 on top of max_integer.
module hpack_header_field_parser #(
	parameter int INT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input octets
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        block_end,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  item_kind,
	output logic [2:0]  rep_type,
	output logic [31:0] int_value,
	output logic [7:0]  string_byte,
	output logic        huff_flag,
	output logic        string_last,
	output logic        field_done,
	output logic [2:0]  error_code
);
	import hpfp_pkg::*;

	// Accumulator and remaining-length registers never need more than the integer cap.
	localparam int ACC_W = (INT_WIDTH < 32) ? INT_WIDTH : 32;

	// Configuration registers
	logic [31:0] max_integer_q;
	logic [15:0] max_name_len_q;
	logic [15:0] max_value_len_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Per-block parse state
	ctl_t             ctl_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] rem_q;

	ctl_t             ctl_n;
	logic [ACC_W-1:0] acc_n;
	logic [ACC_W-1:0] rem_n;
	res_t             res_n;

	// Result register
	logic out_valid_q;
	res_t res_q;

	logic adv; // the octet in the input stage moves into the result register

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_integer_q   <= MAX_INTEGER_RST;
			max_name_len_q  <= MAX_NAME_LEN_RST;
			max_value_len_q <= MAX_VALUE_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_INTEGER:   max_integer_q   <= cfg_data;
				CFG_MAX_NAME_LEN:  max_name_len_q  <= cfg_data[15:0];
				CFG_MAX_VALUE_LEN: max_value_len_q <= cfg_data[15:0];
				default: ; // writes past the register list are dropped
			endcase
		end
	end

	// The result register frees up the cycle it is taken, so a steady stream flows at one octet
	// per cycle while out_ready stays high, even with the input stage full.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			end_s1  <= block_end;
		end
	end

	hpfp_step #(
		.ACC_W (ACC_W)
	) u_step (
		.ctl           (ctl_q),
		.acc           (acc_q),
		.rem           (rem_q),
		.in_byte       (byte_s1),
		.blk_end       (end_s1),
		.max_integer   (max_integer_q),
		.max_name_len  (max_name_len_q),
		.max_value_len (max_value_len_q),
		.ctl_n         (ctl_n),
		.acc_n         (acc_n),
		.rem_n         (rem_n),
		.res           (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
			acc_q <= '0;
			rem_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_n;
			acc_q <= acc_n;
			rem_q <= rem_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= res_n;
	end

	assign out_valid   = out_valid_q;
	assign item_kind   = res_q.item_kind;
	assign rep_type    = res_q.rep_type;
	assign int_value   = res_q.int_value;
	assign string_byte = res_q.string_byte;
	assign huff_flag   = res_q.huff_flag;
	assign string_last = res_q.string_last;
	assign field_done  = res_q.field_done;
	assign error_code  = res_q.error_code;

endmodule

[design/hpfp_checker.sv]
// Port-level checks for the HPACK header field parser, bound to the top level.
module hpfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  item_kind,
	input logic [2:0]  rep_type,
	input logic [31:0] int_value,
	input logic [7:0]  string_byte,
	input logic        huff_flag,
	input logic        string_last,
	input logic        field_done,
	input logic [2:0]  error_code
);
	import hpfp_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(int_value)
			&& $stable(string_byte) && $stable(error_code))
		else $error("result changed while stalled");

	// error results carry nothing but the type and the code
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> item_kind == KIND_INT_MORE
			&& int_value == 32'd0 && string_byte == 8'd0 && !huff_flag
			&& !string_last && !field_done)
		else $error("error result carries payload");

	// a field ends only on a completed index or size update, an empty value or the last value octet
	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_done |-> error_code == ERR_NONE
			&& (item_kind == KIND_INT_DONE || item_kind == KIND_VALUE_LEN
			|| item_kind == KIND_VALUE_BYTE))
		else $error("field done on wrong item");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_last |-> item_kind == KIND_NAME_BYTE
			|| item_kind == KIND_VALUE_BYTE)
		else $error("string end on non-string item");

	// a completed indexed field never refers to entry zero
	a_nonzero_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_done && rep_type == REP_INDEXED |-> int_value != 32'd0)
		else $error("indexed field with index zero");

endmodule

bind hpack_header_field_parser hpfp_checker u_hpfp_checker (.*);
